// ===== rtl/dstc_pkg.sv =====
// shared constants and types for the dual sensor train classifier
package dstc_pkg;

	// default sizes of the sector array, the timestamps and the clear counters
	localparam int NUM_SECTORS_DEF = 4;
	localparam int TIME_WIDTH_DEF  = 48;
	localparam int COUNT_WIDTH_DEF = 8;

	// fixed port widths
	localparam int SENSOR_W      = 4;
	localparam int PORT_TIME_W   = 48;
	localparam int REC_SECTOR_W  = 2;
	localparam int CLEAR_LIMIT_W = 8;

	localparam logic [CLEAR_LIMIT_W-1:0] CLEAR_LIMIT_RST = 8'd10;

	// per-sector passage state
	typedef enum logic [2:0] {
		MODE_IDLE  = 3'b001,
		MODE_TALL  = 3'b010,
		MODE_CHECK = 3'b100
	} mode_t;

endpackage

// ===== rtl/dual_sensor_train_classifier_unit.sv =====
// top level of the dual sensor train classifier
//
// usage:
//   - cfg_wr_en/cfg_wr_data write the clear limit (reset value 10),
//     only while no item is in flight
//   - the input channel (in_valid/in_ready) takes one sensor sample per item:
//     top and bottom sensor bits per sector and the tick's timestamp
//   - the output channel (out_valid/out_ready) gives exactly one result per
//     item: update flags and the tall and low train records after that tick
// timing:
//   - the item is captured in the input register; once the result register is free,
//     all sectors run in one pass and the result register loads
//   - throughput is one item per cycle while results are taken; the per-sector update
//     and the chained record shifts over the sectors sit in one combinational pass
// reset:
//   - all sectors go idle, counters and records clear, both registers empty
// stall:
//   - while a result waits, one more item is still taken into the input
//     register; after that in_ready drops until the result is taken
module dual_sensor_train_classifier_unit #(
	parameter int NUM_SECTORS = dstc_pkg::NUM_SECTORS_DEF,
	parameter int TIME_WIDTH  = dstc_pkg::TIME_WIDTH_DEF,
	parameter int COUNT_WIDTH = dstc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// configuration
	input  logic                                   cfg_wr_en,
	input  logic [dstc_pkg::CLEAR_LIMIT_W-1:0]     cfg_wr_data,
	// sample input
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [dstc_pkg::SENSOR_W-1:0]          top_sensors,
	input  logic [dstc_pkg::SENSOR_W-1:0]          bottom_sensors,
	input  logic [dstc_pkg::PORT_TIME_W-1:0]       time_now,
	// result output
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic                                   tall_updated,
	output logic [dstc_pkg::REC_SECTOR_W-1:0]      tall_sector,
	output logic [dstc_pkg::REC_SECTOR_W-1:0]      tall_prev_sector,
	output logic [dstc_pkg::PORT_TIME_W-1:0]       tall_time,
	output logic [dstc_pkg::PORT_TIME_W-1:0]       tall_prev_time,
	output logic                                   low_updated,
	output logic [dstc_pkg::REC_SECTOR_W-1:0]      low_sector,
	output logic [dstc_pkg::REC_SECTOR_W-1:0]      low_prev_sector,
	output logic [dstc_pkg::PORT_TIME_W-1:0]       low_time,
	output logic [dstc_pkg::PORT_TIME_W-1:0]       low_prev_time
);

	// threshold compare width covers both the register and the counter
	localparam int THR_W = (COUNT_WIDTH > dstc_pkg::CLEAR_LIMIT_W) ?
		COUNT_WIDTH : dstc_pkg::CLEAR_LIMIT_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
	localparam logic [THR_W-1:0] CNT_MAX_EXT = THR_W'(CNT_MAX);

	localparam int SW  = dstc_pkg::SENSOR_W;
	localparam int PTW = dstc_pkg::PORT_TIME_W;
	localparam int RSW = dstc_pkg::REC_SECTOR_W;

	// configuration register
	logic [dstc_pkg::CLEAR_LIMIT_W-1:0] clear_limit_q;

	// input register
	logic                 valid_s1;
	logic [SW-1:0]        top_s1;
	logic [SW-1:0]        bottom_s1;
	logic [PTW-1:0]       time_s1;

	// per-sector state
	dstc_pkg::mode_t      mode_q     [NUM_SECTORS];
	logic [TIME_WIDTH-1:0] entry_q   [NUM_SECTORS];
	logic [COUNT_WIDTH-1:0] tall_cnt_q [NUM_SECTORS];
	logic [COUNT_WIDTH-1:0] low_cnt_q  [NUM_SECTORS];

	// train records, current and previous passage
	logic [RSW-1:0]        tall_cur_sector_q, tall_prev_sector_q;
	logic [TIME_WIDTH-1:0] tall_cur_time_q, tall_prev_time_q;
	logic [RSW-1:0]        low_cur_sector_q, low_prev_sector_q;
	logic [TIME_WIDTH-1:0] low_cur_time_q, low_prev_time_q;

	// result register
	logic           out_valid_q;
	logic           tall_upd_q, low_upd_q;
	logic [RSW-1:0] tall_sector_q, tall_prev_sector_q2, low_sector_q, low_prev_sector_q2;
	logic [PTW-1:0] tall_time_q, tall_prev_time_q2, low_time_q, low_prev_time_q2;

	// next-state values from the single pass
	dstc_pkg::mode_t        mode_d     [NUM_SECTORS];
	logic [TIME_WIDTH-1:0]  entry_d    [NUM_SECTORS];
	logic [COUNT_WIDTH-1:0] tall_cnt_d [NUM_SECTORS];
	logic [COUNT_WIDTH-1:0] low_cnt_d  [NUM_SECTORS];
	logic [RSW-1:0]         tall_cur_sector_d, tall_prev_sector_d;
	logic [TIME_WIDTH-1:0]  tall_cur_time_d, tall_prev_time_d;
	logic [RSW-1:0]         low_cur_sector_d, low_prev_sector_d;
	logic [TIME_WIDTH-1:0]  low_cur_time_d, low_prev_time_d;
	logic                   tall_upd_d, low_upd_d;

	logic                   out_free;
	logic                   adv_s1;
	logic [THR_W-1:0]       thr;
	logic [NUM_SECTORS-1:0] top_n, bottom_n;
	logic [TIME_WIDTH-1:0]  now_w;
	logic [NUM_SECTORS+SW-1:0]       top_ext, bottom_ext;
	logic [TIME_WIDTH+PTW-1:0]       now_ext;
	logic [TIME_WIDTH+PTW-1:0]       tc_ext, tp_ext, lc_ext, lp_ext;

	// handshake: the result register frees when empty or taken
	assign out_free = !out_valid_q || out_ready;
	assign adv_s1   = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	// sensor bits beyond the sector count are dropped, missing ones read zero
	assign top_ext    = {{NUM_SECTORS{1'b0}}, top_s1};
	assign bottom_ext = {{NUM_SECTORS{1'b0}}, bottom_s1};
	assign top_n      = top_ext[NUM_SECTORS-1:0];
	assign bottom_n   = bottom_ext[NUM_SECTORS-1:0];
	assign now_ext    = {{TIME_WIDTH{1'b0}}, time_s1};
	assign now_w      = now_ext[TIME_WIDTH-1:0];

	// zero threshold acts as one, too large clamps to the counter maximum
	always_comb begin
		if (clear_limit_q == '0) begin
			thr = THR_W'(1);
		end else if (THR_W'(clear_limit_q) > CNT_MAX_EXT) begin
			thr = CNT_MAX_EXT;
		end else begin
			thr = THR_W'(clear_limit_q);
		end
	end

	// all sectors in order, each end of passage shifting its record
	always_comb begin
		logic [COUNT_WIDTH-1:0] inc;
		mode_d             = mode_q;
		entry_d            = entry_q;
		tall_cnt_d         = tall_cnt_q;
		low_cnt_d          = low_cnt_q;
		tall_cur_sector_d  = tall_cur_sector_q;
		tall_prev_sector_d = tall_prev_sector_q;
		tall_cur_time_d    = tall_cur_time_q;
		tall_prev_time_d   = tall_prev_time_q;
		low_cur_sector_d   = low_cur_sector_q;
		low_prev_sector_d  = low_prev_sector_q;
		low_cur_time_d     = low_cur_time_q;
		low_prev_time_d    = low_prev_time_q;
		tall_upd_d         = 1'b0;
		low_upd_d          = 1'b0;
		inc                = '0;
		for (int s = 0; s < NUM_SECTORS; s++) begin
			unique case (mode_q[s])
				dstc_pkg::MODE_TALL: begin
					inc = (tall_cnt_q[s] == CNT_MAX) ? tall_cnt_q[s] : tall_cnt_q[s] + 1'b1;
					if (!bottom_n[s]) begin
						if (THR_W'(inc) >= thr) begin
							tall_cnt_d[s]      = '0;
							mode_d[s]          = dstc_pkg::MODE_IDLE;
							tall_prev_sector_d = tall_cur_sector_d;
							tall_prev_time_d   = tall_cur_time_d;
							tall_cur_sector_d  = RSW'(s);
							tall_cur_time_d    = entry_q[s];
							tall_upd_d         = 1'b1;
						end else begin
							tall_cnt_d[s] = inc;
						end
					end else begin
						tall_cnt_d[s] = '0;
					end
				end
				dstc_pkg::MODE_CHECK: begin
					inc = (low_cnt_q[s] == CNT_MAX) ? low_cnt_q[s] : low_cnt_q[s] + 1'b1;
					if (top_n[s]) begin
						// low count is kept for the next checking passage
						mode_d[s]  = dstc_pkg::MODE_TALL;
						entry_d[s] = now_w;
					end else if (!bottom_n[s]) begin
						if (THR_W'(inc) >= thr) begin
							low_cnt_d[s]      = '0;
							mode_d[s]         = dstc_pkg::MODE_IDLE;
							low_prev_sector_d = low_cur_sector_d;
							low_prev_time_d   = low_cur_time_d;
							low_cur_sector_d  = RSW'(s);
							low_cur_time_d    = entry_q[s];
							low_upd_d         = 1'b1;
						end else begin
							low_cnt_d[s] = inc;
						end
					end else begin
						low_cnt_d[s] = '0;
					end
				end
				default: begin
					// idle, and any stray code behaves the same
					if (top_n[s]) begin
						mode_d[s]  = dstc_pkg::MODE_TALL;
						entry_d[s] = now_w;
					end else if (bottom_n[s]) begin
						mode_d[s]  = dstc_pkg::MODE_CHECK;
						entry_d[s] = now_w;
					end else begin
						mode_d[s] = dstc_pkg::MODE_IDLE;
					end
				end
			endcase
		end
	end

	// record times to the port width
	assign tc_ext = {{PTW{1'b0}}, tall_cur_time_d};
	assign tp_ext = {{PTW{1'b0}}, tall_prev_time_d};
	assign lc_ext = {{PTW{1'b0}}, low_cur_time_d};
	assign lp_ext = {{PTW{1'b0}}, low_prev_time_d};

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_limit_q <= dstc_pkg::CLEAR_LIMIT_RST;
		end else if (cfg_wr_en) begin
			clear_limit_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			top_s1    <= top_sensors;
			bottom_s1 <= bottom_sensors;
			time_s1   <= time_now;
		end
	end

	// sector state and records advance once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SECTORS; s++) begin
				mode_q[s]     <= dstc_pkg::MODE_IDLE;
				entry_q[s]    <= '0;
				tall_cnt_q[s] <= '0;
				low_cnt_q[s]  <= '0;
			end
			tall_cur_sector_q  <= '0;
			tall_prev_sector_q <= '0;
			tall_cur_time_q    <= '0;
			tall_prev_time_q   <= '0;
			low_cur_sector_q   <= '0;
			low_prev_sector_q  <= '0;
			low_cur_time_q     <= '0;
			low_prev_time_q    <= '0;
		end else if (adv_s1) begin
			mode_q             <= mode_d;
			entry_q            <= entry_d;
			tall_cnt_q         <= tall_cnt_d;
			low_cnt_q          <= low_cnt_d;
			tall_cur_sector_q  <= tall_cur_sector_d;
			tall_prev_sector_q <= tall_prev_sector_d;
			tall_cur_time_q    <= tall_cur_time_d;
			tall_prev_time_q   <= tall_prev_time_d;
			low_cur_sector_q   <= low_cur_sector_d;
			low_prev_sector_q  <= low_prev_sector_d;
			low_cur_time_q     <= low_cur_time_d;
			low_prev_time_q    <= low_prev_time_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			tall_upd_q          <= tall_upd_d;
			tall_sector_q       <= tall_cur_sector_d;
			tall_prev_sector_q2 <= tall_prev_sector_d;
			tall_time_q         <= tc_ext[PTW-1:0];
			tall_prev_time_q2   <= tp_ext[PTW-1:0];
			low_upd_q           <= low_upd_d;
			low_sector_q        <= low_cur_sector_d;
			low_prev_sector_q2  <= low_prev_sector_d;
			low_time_q          <= lc_ext[PTW-1:0];
			low_prev_time_q2    <= lp_ext[PTW-1:0];
		end
	end

	assign out_valid        = out_valid_q;
	assign tall_updated     = tall_upd_q;
	assign tall_sector      = tall_sector_q;
	assign tall_prev_sector = tall_prev_sector_q2;
	assign tall_time        = tall_time_q;
	assign tall_prev_time   = tall_prev_time_q2;
	assign low_updated      = low_upd_q;
	assign low_sector       = low_sector_q;
	assign low_prev_sector  = low_prev_sector_q2;
	assign low_time         = low_time_q;
	assign low_prev_time    = low_prev_time_q2;

	// an item that moves out of the input register shows up as a result
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> out_valid)
		else $error("item left the input register without a result");

	// the tall record only moves on a tick that reports a tall update
	a_tall_record_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !tall_upd_d) |=> ($stable(tall_cur_time_q) && $stable(tall_cur_sector_q)))
		else $error("tall record changed without a tall update");

	// the low record only moves on a tick that reports a low update
	a_low_record_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !low_upd_d) |=> ($stable(low_cur_time_q) && $stable(low_cur_sector_q)))
		else $error("low record changed without a low update");

endmodule

// ===== verif/train_record_checker.sv =====
`timescale 1ns / 100ps
// checker that predicts the train records per sample and compares every result item
module train_record_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [dstc_pkg::CLEAR_LIMIT_W-1:0]  cfg_wr_data,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic [dstc_pkg::SENSOR_W-1:0]       top_sensors,
	input  logic [dstc_pkg::SENSOR_W-1:0]       bottom_sensors,
	input  logic [dstc_pkg::PORT_TIME_W-1:0]    time_now,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic                                tall_updated,
	input  logic [dstc_pkg::REC_SECTOR_W-1:0]   tall_sector,
	input  logic [dstc_pkg::REC_SECTOR_W-1:0]   tall_prev_sector,
	input  logic [dstc_pkg::PORT_TIME_W-1:0]    tall_time,
	input  logic [dstc_pkg::PORT_TIME_W-1:0]    tall_prev_time,
	input  logic                                low_updated,
	input  logic [dstc_pkg::REC_SECTOR_W-1:0]   low_sector,
	input  logic [dstc_pkg::REC_SECTOR_W-1:0]   low_prev_sector,
	input  logic [dstc_pkg::PORT_TIME_W-1:0]    low_time,
	input  logic [dstc_pkg::PORT_TIME_W-1:0]    low_prev_time,
	output int                                  pending_results,
	output int                                  mismatch_count
);

	localparam int NSEC    = dstc_pkg::NUM_SECTORS_DEF;
	localparam int CW      = dstc_pkg::COUNT_WIDTH_DEF;
	localparam int CNT_MAX = (1 << CW) - 1;
	localparam int SW      = dstc_pkg::SENSOR_W;
	localparam int PTW     = dstc_pkg::PORT_TIME_W;
	localparam int RSW     = dstc_pkg::REC_SECTOR_W;
	localparam int LW      = dstc_pkg::CLEAR_LIMIT_W;

	typedef struct packed {
		logic           tall_upd;
		logic [RSW-1:0] tall_sec;
		logic [RSW-1:0] tall_prev_sec;
		logic [PTW-1:0] tall_t;
		logic [PTW-1:0] tall_prev_t;
		logic           low_upd;
		logic [RSW-1:0] low_sec;
		logic [RSW-1:0] low_prev_sec;
		logic [PTW-1:0] low_t;
		logic [PTW-1:0] low_prev_t;
	} tick_result_t;

	dstc_pkg::mode_t  sec_mode   [NSEC];
	logic [PTW-1:0]   sec_entry  [NSEC];
	logic [CW-1:0]    tall_clear [NSEC];
	logic [CW-1:0]    low_clear  [NSEC];
	logic [RSW-1:0]   tall_rec_sec [2];
	logic [PTW-1:0]   tall_rec_t   [2];
	logic [RSW-1:0]   low_rec_sec  [2];
	logic [PTW-1:0]   low_rec_t    [2];
	logic [LW-1:0]    clear_limit;
	tick_result_t     expected_q [$];

	// one clear tick on a saturating counter, -1 means the passage is over
	function automatic int next_clear(int cnt, int thr);
		int n;
		n = (cnt < CNT_MAX) ? cnt + 1 : cnt;
		return (n >= thr) ? -1 : n;
	endfunction

	function automatic tick_result_t advance_sectors(logic [SW-1:0] top,
			logic [SW-1:0] bot, logic [PTW-1:0] now);
		tick_result_t r;
		int thr;
		int n;
		logic tall_hit;
		logic low_hit;
		thr = (clear_limit == 0) ? 1 : int'(clear_limit);
		if (thr > CNT_MAX) thr = CNT_MAX;
		tall_hit = 1'b0;
		low_hit  = 1'b0;
		for (int s = 0; s < NSEC; s++) begin
			case (sec_mode[s])
				dstc_pkg::MODE_TALL: begin
					if (bot[s]) begin
						tall_clear[s] = '0;
					end else begin
						n = next_clear(int'(tall_clear[s]), thr);
						tall_clear[s] = (n < 0) ? '0 : CW'(n);
						if (n < 0) begin
							sec_mode[s]     = dstc_pkg::MODE_IDLE;
							tall_rec_sec[1] = tall_rec_sec[0];
							tall_rec_t[1]   = tall_rec_t[0];
							tall_rec_sec[0] = RSW'(s);
							tall_rec_t[0]   = sec_entry[s];
							tall_hit        = 1'b1;
						end
					end
				end
				dstc_pkg::MODE_CHECK: begin
					// low count is kept when checking turns tall
					if (top[s]) begin
						sec_mode[s]  = dstc_pkg::MODE_TALL;
						sec_entry[s] = now;
					end else if (bot[s]) begin
						low_clear[s] = '0;
					end else begin
						n = next_clear(int'(low_clear[s]), thr);
						low_clear[s] = (n < 0) ? '0 : CW'(n);
						if (n < 0) begin
							sec_mode[s]    = dstc_pkg::MODE_IDLE;
							low_rec_sec[1] = low_rec_sec[0];
							low_rec_t[1]   = low_rec_t[0];
							low_rec_sec[0] = RSW'(s);
							low_rec_t[0]   = sec_entry[s];
							low_hit        = 1'b1;
						end
					end
				end
				default: begin
					if (top[s]) begin
						sec_mode[s]  = dstc_pkg::MODE_TALL;
						sec_entry[s] = now;
					end else if (bot[s]) begin
						sec_mode[s]  = dstc_pkg::MODE_CHECK;
						sec_entry[s] = now;
					end else begin
						sec_mode[s] = dstc_pkg::MODE_IDLE;
					end
				end
			endcase
		end
		r.tall_upd      = tall_hit;
		r.tall_sec      = tall_rec_sec[0];
		r.tall_prev_sec = tall_rec_sec[1];
		r.tall_t        = tall_rec_t[0];
		r.tall_prev_t   = tall_rec_t[1];
		r.low_upd       = low_hit;
		r.low_sec       = low_rec_sec[0];
		r.low_prev_sec  = low_rec_sec[1];
		r.low_t         = low_rec_t[0];
		r.low_prev_t    = low_rec_t[1];
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic compare_field(string field, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", field, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		tick_result_t want;
		if (!arst_n) begin
			clear_limit = dstc_pkg::CLEAR_LIMIT_RST;
			for (int s = 0; s < NSEC; s++) begin
				sec_mode[s]   = dstc_pkg::MODE_IDLE;
				sec_entry[s]  = '0;
				tall_clear[s] = '0;
				low_clear[s]  = '0;
			end
			for (int k = 0; k < 2; k++) begin
				tall_rec_sec[k] = '0;
				tall_rec_t[k]   = '0;
				low_rec_sec[k]  = '0;
				low_rec_t[k]    = '0;
			end
			expected_q.delete();
			pending_results <= 0;
		end else begin
			if (cfg_wr_en) clear_limit = cfg_wr_data;
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result item with no sample waiting");
				end else begin
					want = expected_q.pop_front();
					compare_field("tall_updated", 64'(tall_updated), 64'(want.tall_upd));
					compare_field("tall_sector", 64'(tall_sector), 64'(want.tall_sec));
					compare_field("tall_prev_sector", 64'(tall_prev_sector),
						64'(want.tall_prev_sec));
					compare_field("tall_time", 64'(tall_time), 64'(want.tall_t));
					compare_field("tall_prev_time", 64'(tall_prev_time),
						64'(want.tall_prev_t));
					compare_field("low_updated", 64'(low_updated), 64'(want.low_upd));
					compare_field("low_sector", 64'(low_sector), 64'(want.low_sec));
					compare_field("low_prev_sector", 64'(low_prev_sector),
						64'(want.low_prev_sec));
					compare_field("low_time", 64'(low_time), 64'(want.low_t));
					compare_field("low_prev_time", 64'(low_prev_time), 64'(want.low_prev_t));
				end
			end
			if (in_valid && in_ready)
				expected_q.push_back(advance_sectors(top_sensors, bottom_sensors, time_now));
			pending_results <= expected_q.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// top of the classifier testbench: stimulus, handshakes and the verdict
module testbench;

	localparam int SW   = dstc_pkg::SENSOR_W;
	localparam int PTW  = dstc_pkg::PORT_TIME_W;
	localparam int RSW  = dstc_pkg::REC_SECTOR_W;
	localparam int LW   = dstc_pkg::CLEAR_LIMIT_W;
	localparam int NSEC = dstc_pkg::NUM_SECTORS_DEF;

	logic            clk = 1'b0;
	logic            arst_n;
	logic            cfg_wr_en;
	logic [LW-1:0]   cfg_wr_data;
	logic            in_valid;
	logic            in_ready;
	logic [SW-1:0]   top_sensors;
	logic [SW-1:0]   bottom_sensors;
	logic [PTW-1:0]  time_now;
	logic            out_valid;
	logic            out_ready;
	logic            tall_updated;
	logic [RSW-1:0]  tall_sector;
	logic [RSW-1:0]  tall_prev_sector;
	logic [PTW-1:0]  tall_time;
	logic [PTW-1:0]  tall_prev_time;
	logic            low_updated;
	logic [RSW-1:0]  low_sector;
	logic [RSW-1:0]  low_prev_sector;
	logic [PTW-1:0]  low_time;
	logic [PTW-1:0]  low_prev_time;
	int              pending_results;
	int              mismatch_count;

	// stimulus bookkeeping
	int              idle_level = 0;    // 0 no idling, 1 light, 2 heavy
	bit              tail_calm  = 1'b0; // last part of the run, no idling at all
	int              items_sent = 0;
	int              settings_used = 0;
	logic [PTW-1:0]  clock_ns = '0;
	int              train_left [NSEC];
	bit              train_tall [NSEC];

	dual_sensor_train_classifier_unit u_top (.*);

	// watches both channels and the config port, predicts and compares
	train_record_checker u_checker (.*);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// hard stop in case the handshakes hang
	initial begin
		#6_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// result side: random stall bursts while idling is enabled
	initial begin
		out_ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (!tail_calm && idle_level != 0 &&
					$urandom_range(0, (idle_level == 1) ? 10 : 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	// present one sample and hold it until accepted; valid stays high on return
	task automatic send_item(logic [SW-1:0] top, logic [SW-1:0] bot,
			logic [PTW-1:0] stamp);
		// an optional sender gap with in_valid held low
		if (!tail_calm && idle_level != 0 &&
				$urandom_range(0, (idle_level == 1) ? 12 : 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid       <= 1'b1;
		top_sensors    <= top;
		bottom_sensors <= bot;
		time_now       <= stamp;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// drain every outstanding result, let the pipe settle, then write the clear limit
	task automatic set_clear_limit(logic [LW-1:0] value);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
		repeat (3) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	// next sensor sample: per-sector train passages with some flicker and noise
	task automatic next_sample(bit calm, int start_odds,
			output logic [SW-1:0] top, output logic [SW-1:0] bot);
		for (int s = 0; s < NSEC; s++) begin
			if (train_left[s] != 0) begin
				// a passing train; the bottom sensor flickers now and then
				bot[s] = ($urandom_range(0, 9) != 0);
				// low trains sometimes show on the top sensor too (checking to tall)
				top[s] = train_tall[s] ? ($urandom_range(0, 2) != 0)
					: ($urandom_range(0, 11) == 0);
				train_left[s]--;
			end else if (!calm && $urandom_range(0, start_odds) == 0) begin
				train_left[s] = $urandom_range(1, 8);
				train_tall[s] = 1'($urandom_range(0, 1));
				top[s] = train_tall[s];
				bot[s] = !train_tall[s] || ($urandom_range(0, 1) == 1);
			end else begin
				top[s] = 1'b0;
				bot[s] = 1'b0;
			end
		end
		// plain noise on top of the passages
		if (!calm && $urandom_range(0, 15) == 0) begin
			top = SW'($urandom);
			bot = SW'($urandom);
		end
	endtask

	// one setting of the clear limit followed by random samples; no new trains start after calm_after
	task automatic run_phase(logic [LW-1:0] thr, int count, int start_odds,
			int calm_after);
		logic [SW-1:0] top;
		logic [SW-1:0] bot;
		set_clear_limit(thr);
		for (int i = 0; i < count; i++) begin
			// idling density changes every hundred samples, sometimes none at all
			if (i % 100 == 0) idle_level = $urandom_range(0, 2);
			case ($urandom_range(0, 31))
				0:       clock_ns = PTW'({$urandom, $urandom});
				1:       clock_ns = {PTW{1'b1}} - $urandom_range(0, 4000);
				default: clock_ns = clock_ns + $urandom_range(1, 5000);
			endcase
			next_sample(i >= calm_after, start_odds, top, bot);
			send_item(top, bot, clock_ns);
		end
	endtask

	initial begin
		arst_n         <= 1'b0;
		cfg_wr_en      <= 1'b0;
		cfg_wr_data    <= '0;
		in_valid       <= 1'b0;
		top_sensors    <= '0;
		bottom_sensors <= '0;
		time_now       <= '0;
		for (int s = 0; s < NSEC; s++) begin
			train_left[s] = 0;
			train_tall[s] = 1'b0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, threshold 1: every clear tick ends a passage
		set_clear_limit(8'd1);
		send_item(4'h0, 4'h0, 48'h0);
		// all sectors go tall at the largest time, then end together so
		// the tall record shifts four times in one tick, sector 0 first
		send_item(4'hF, 4'h0, 48'hFFFF_FFFF_FFFF);
		send_item(4'h0, 4'h0, 48'h5555_5555_5555);
		// all sectors into checking, then held by a blocked bottom sensor
		send_item(4'h0, 4'hF, 48'hAAAA_AAAA_AAAA);
		send_item(4'h0, 4'hF, 48'h1);
		// sectors 0 and 2 turn tall while 1 and 3 end as low passages
		send_item(4'h5, 4'h0, 48'h2);
		send_item(4'h0, 4'hA, 48'h3);
		send_item(4'hA, 4'h0, 48'h4);
		send_item(4'h0, 4'h0, 48'h5);

		// threshold 2: a low count left in checking carries over past a tall passage
		set_clear_limit(8'd2);
		send_item(4'h0, 4'h1, 48'h10);
		send_item(4'h0, 4'h0, 48'h11);
		send_item(4'h1, 4'h0, 48'h12);
		send_item(4'h0, 4'h0, 48'h13);
		send_item(4'h0, 4'h1, 48'h14);
		send_item(4'h0, 4'h0, 48'h15);
		send_item(4'h0, 4'h0, 48'h16);
		send_item(4'h0, 4'h1, 48'h17);
		send_item(4'h0, 4'h0, 48'h18);

		// threshold 0 acts as 1; top and bottom both blocked from idle goes tall
		set_clear_limit(8'd0);
		send_item(4'hF, 4'hF, 48'hFFFF_FFFF_FFFE);
		send_item(4'h0, 4'h0, 48'h8000_0000_0000);

		// random part over several settings, the extremes among them
		run_phase(8'd3, 280, 5, 280);
		// longest threshold: trains only at the start, then a long clear stretch
		run_phase(8'd255, 300, 4, 30);
		run_phase(8'd1, 220, 3, 220);
		run_phase(LW'($urandom_range(2, 16)), 250, 12, 250);
		run_phase(dstc_pkg::CLEAR_LIMIT_RST, 200, 30, 200);
		// closing stretch without any idling on either side
		tail_calm = 1'b1;
		run_phase(LW'($urandom_range(1, 8)), 180, 8, 180);

		// wait for the last results and let the bench settle
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
		repeat (4) @(posedge clk);

		$display("run covered %0d sensor samples over %0d clear threshold settings",
			items_sent, settings_used);
		$display("including chained record shifts, count carry-over and thresholds 0 and 255");
		if (mismatch_count == 0 && pending_results == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/dstc_pkg.sv
rtl/dual_sensor_train_classifier_unit.sv
verif/train_record_checker.sv
verif/testbench.sv
